@@ design/drrip_replacement_policy_unit_macros.svh @@
// ---------------------------------------------------------------------------
// drrip_replacement_policy_unit_macros.svh
// Assertion helpers for the replacement policy block. All of them sample on
// clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef DRRIP_REPLACEMENT_POLICY_UNIT_MACROS_SVH
`define DRRIP_REPLACEMENT_POLICY_UNIT_MACROS_SVH

// Same-cycle implication.
`define DRRIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DRRIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/drrip_pkg.sv @@
// ---------------------------------------------------------------------------
// drrip_pkg
// Sizes, payload types and shared constants of the replacement policy block.
// ---------------------------------------------------------------------------
`default_nettype none

package drrip_pkg;

  // Geometry (SETS is a power of two)
  localparam int SETS      = 256;
  localparam int WAYS      = 8;
  localparam int RRPV_BITS = 2;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = $clog2(WAYS);

  localparam logic [RRPV_BITS-1:0] RRPV_MAX  = '1;
  localparam logic [RRPV_BITS-1:0] RRPV_LONG = RRPV_MAX - 1'b1;

  // Duel counter and LFSR
  localparam int CTR_W = 10;
  localparam logic [CTR_W-1:0] CTR_RESET = 10'h200;
  localparam logic [CTR_W-1:0] CTR_MAX   = 10'h3FF;
  localparam logic [15:0]      LFSR_SEED = 16'hACE1;

  // Operation codes
  localparam logic OP_HIT  = 1'b0;
  localparam logic OP_MISS = 1'b1;

  typedef logic [WAYS-1:0][RRPV_BITS-1:0] row_t;

  localparam row_t ROW_RESET = '1;

  typedef struct packed {
    logic       op;
    logic [7:0] set_index;
    logic [2:0] hit_way;
    logic [7:0] valid_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0] victim_way;
    logic       is_fill;
    logic       chose_empty;
    logic [1:0] inserted_value;
    logic       follower_uses_brrip;
  } out_item_t;

  // Row write-back request to the store
  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
    row_t             row;
  } rrpv_wr_t;

endpackage

`default_nettype wire

@@ design/drrip_rrpv_store.sv @@
// ---------------------------------------------------------------------------
// drrip_rrpv_store
// Per-set row of re-reference values. One registered read port, one write
// port. A per-set valid flop makes never-written rows read as all-distant.
// ---------------------------------------------------------------------------
`default_nettype none

module drrip_rrpv_store (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [drrip_pkg::SET_W-1:0] rd_set_i,
  output      drrip_pkg::row_t             rd_row_o,
  input  wire drrip_pkg::rrpv_wr_t         wr_i
);
  import drrip_pkg::*;

  row_t            mem [SETS];
  logic [SETS-1:0] vld_q;
  row_t            rd_row_q;

  // Write the row array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.set] <= wr_i.row;
    end
  end

  // Mark written rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.set] <= 1'b1;
    end
  end

  // Register the read data, substituting the reset row when unwritten
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= vld_q[rd_set_i] ? mem[rd_set_i] : ROW_RESET;
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

`default_nettype wire

@@ design/drrip_replacement_policy_unit.sv @@
// ---------------------------------------------------------------------------
// drrip_replacement_policy_unit
// Set-dueling re-reference replacement policy with one shared way scanner.
// ---------------------------------------------------------------------------
// One access is handled at a time; in_stall_o is high from acceptance until
// the result is loaded into the output register. A hit or a fill into an
// invalid way passes accept, row read and write-back. An evicting miss adds a
// scan, where the single compare unit walks the ways one per cycle to find the
// lowest-numbered way with the highest value, and an aging step that ages the
// set, updates the duel counter and, under the bimodal policy, steps the LFSR.
// The row read and write-back use the one port pair of the set store; sets
// never written read as all ways distant, so no clearing pass follows reset.
`default_nettype none

module drrip_replacement_policy_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire drrip_pkg::in_item_t  in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      drrip_pkg::out_item_t out_data_o
);
  import drrip_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_AGE    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam logic [WAY_W-1:0] WAY_LAST = WAY_W'(WAYS - 1);

  logic [2:0]           state_q, state_d;
  in_item_t             req_q, req_d;
  row_t                 row_q, row_d;
  logic [WAY_W-1:0]     cnt_q, cnt_d;
  logic [RRPV_BITS-1:0] max_q, max_d;
  logic [WAY_W-1:0]     vic_q, vic_d;
  logic [RRPV_BITS-1:0] ins_q, ins_d;
  logic                 empty_q, empty_d;
  logic [CTR_W-1:0]     ctr_q, ctr_d;
  logic [15:0]          lfsr_q, lfsr_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  row_t                 rd_row;
  rrpv_wr_t             wr;
  logic [SET_W-1:0]     in_set, req_set;
  logic [WAYS+7:0]      vmask_ext;
  logic                 free_found;
  logic [WAY_W-1:0]     free_way;
  logic [31:0]          set_ext;
  logic                 srrip_lead, brrip_lead, use_brrip;
  logic [CTR_W-1:0]     ctr_upd;
  logic [15:0]          lfsr_step;
  logic                 hit_in_range;
  row_t                 row_fin;

  // Reduce set numbers to the store depth
  assign in_set  = SET_W'({24'd0, in_data_i.set_index} % SETS);
  assign req_set = SET_W'({24'd0, req_q.set_index} % SETS);

  drrip_rrpv_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_valid_i && (state_q == ST_IDLE)),
    .rd_set_i (in_set),
    .rd_row_o (rd_row),
    .wr_i     (wr)
  );

  // Find the lowest invalid way; ways past the mask count as valid
  assign vmask_ext = {{WAYS{1'b1}}, req_q.valid_mask};

  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vmask_ext[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  // Classify leader sets and step the duel counter
  assign set_ext    = 32'(req_set);
  assign srrip_lead = (set_ext[4:0] == set_ext[9:5]);
  assign brrip_lead = ((~set_ext[4:0]) == set_ext[9:5]);

  always_comb begin
    ctr_upd = ctr_q;
    if (srrip_lead && (ctr_q != CTR_MAX)) begin
      ctr_upd = ctr_q + 1'b1;
    end
    if (brrip_lead && (ctr_q != '0)) begin
      ctr_upd = ctr_q - 1'b1;
    end
  end

  assign use_brrip = srrip_lead ? 1'b0 : (brrip_lead ? 1'b1 : ctr_upd[CTR_W-1]);
  assign lfsr_step = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  // Build the row to write back
  assign hit_in_range = (32'(req_q.hit_way) < WAYS);

  always_comb begin
    row_fin = row_q;
    if (req_q.op == OP_MISS) begin
      row_fin[vic_q] = ins_q;
    end else if (hit_in_range) begin
      row_fin[WAY_W'(req_q.hit_way)] = '0;
    end
  end

  // Sequence one access
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    max_d       = max_q;
    vic_d       = vic_q;
    ins_d       = ins_q;
    empty_d     = empty_q;
    ctr_d       = ctr_q;
    lfsr_d      = lfsr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr          = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        row_d = rd_row;
        if ((req_q.op == OP_MISS) && free_found) begin
          empty_d = 1'b1;
          vic_d   = free_way;
          ins_d   = RRPV_LONG;
          state_d = ST_FINISH;
        end else if (req_q.op == OP_MISS) begin
          empty_d = 1'b0;
          cnt_d   = '0;
          max_d   = '0;
          vic_d   = '0;
          state_d = ST_SCAN;
        end else begin
          empty_d = 1'b0;
          vic_d   = '0;
          ins_d   = '0;
          state_d = ST_FINISH;
        end
      end
      ST_SCAN: begin
        // Keep the lowest-numbered way holding the highest value
        if (row_q[cnt_q] > max_q) begin
          max_d = row_q[cnt_q];
          vic_d = cnt_q;
        end
        if (cnt_q == WAY_LAST) begin
          state_d = ST_AGE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_AGE: begin
        for (int w = 0; w < WAYS; w++) begin
          row_d[w] = row_q[w] + (RRPV_MAX - max_q);
        end
        ctr_d = ctr_upd;
        if (use_brrip) begin
          lfsr_d = lfsr_step;
          ins_d  = (lfsr_step[4:0] == 5'd0) ? RRPV_LONG : RRPV_MAX;
        end else begin
          ins_d  = RRPV_LONG;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          wr.en                     = 1'b1;
          wr.set                    = req_set;
          wr.row                    = row_fin;
          out_valid_d               = 1'b1;
          out_d.victim_way          = 3'(vic_q);
          out_d.is_fill             = (req_q.op == OP_MISS);
          out_d.chose_empty         = empty_q;
          out_d.inserted_value      = 2'(ins_q);
          out_d.follower_uses_brrip = ctr_q[CTR_W-1];
          state_d                   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and policy state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= CTR_RESET;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    row_q   <= row_d;
    cnt_q   <= cnt_d;
    max_q   <= max_d;
    vic_q   <= vic_d;
    ins_q   <= ins_d;
    empty_q <= empty_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "drrip_replacement_policy_unit_macros.svh"

  `DRRIP_ASSERT_IMP(a_wr_in_finish, wr.en, state_q == ST_FINISH, "row write outside finish")
  `DRRIP_ASSERT_IMP(a_hit_fields, out_valid_o && !out_data_o.is_fill, (out_data_o.victim_way == 3'd0) && !out_data_o.chose_empty && (out_data_o.inserted_value == 2'd0), "hit result carries fill fields")
  `DRRIP_ASSERT_NXT(a_ctr_only_age, state_q != ST_AGE, $stable(ctr_q), "duel counter moved outside aging")

endmodule

`default_nettype wire
